// File: hw/rtl/bsfoc_pkg.sv
`timescale 1ns / 1ps

package bsfoc_pkg;

	// Field widths
	localparam int CAL_W     = 16;
	localparam int RAW_W     = 24;
	localparam int TEMP_W    = 15;
	localparam int PRESS_W   = 18;
	localparam int CFG_IDX_W = 3;

	// Internal arithmetic widths
	localparam int DT_W    = RAW_W + 1;           // raw minus reference, signed
	localparam int PRD_W   = DT_W + CAL_W + 1;    // dT times a calibration word
	localparam int TSUM_W  = 19;                  // temperature before clamping
	localparam int OFF_W   = 36;
	localparam int SENS_W  = 35;
	localparam int LO_W    = 18;                  // low slice of SENS, unsigned
	localparam int HI_W    = SENS_W - LO_W;       // high slice of SENS, signed
	localparam int PP_W    = RAW_W + LO_W;        // partial product width
	localparam int MUL_W   = 60;                  // full raw pressure times SENS
	localparam int PSH_W   = 38;                  // product after the 2^21 shift
	localparam int DIFF_W  = PSH_W + 1;
	localparam int PQ_W    = 24;                  // pressure before clamping

	// Scale and shift amounts
	localparam int REF_SHIFT   = 8;
	localparam int TEMP_SHIFT  = 23;
	localparam int OFF_SCALE   = 17;
	localparam int OFF_SHIFT   = 6;
	localparam int SENS_SCALE  = 16;
	localparam int SENS_SHIFT  = 7;
	localparam int MUL_SHIFT   = 21;
	localparam int PRESS_SHIFT = 15;

	// Output limits
	localparam logic signed [TSUM_W-1:0] TEMP_BASE = 19'sd2000;
	localparam logic signed [TSUM_W-1:0] TEMP_MIN  = -19'sd4000;
	localparam logic signed [TSUM_W-1:0] TEMP_MAX  = 19'sd8500;
	localparam logic signed [PQ_W-1:0]   PRESS_MAX = 24'sd200000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESSURE_SENS     = 3'd0,
		CFG_PRESSURE_OFFSET   = 3'd1,
		CFG_SENS_TEMP_COEFF   = 3'd2,
		CFG_OFFSET_TEMP_COEFF = 3'd3,
		CFG_REFERENCE_TEMP    = 3'd4,
		CFG_TEMP_COEFF        = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [CAL_W-1:0] cal_pressure_sens;
		logic [CAL_W-1:0] cal_pressure_offset;
		logic [CAL_W-1:0] cal_sens_temp_coeff;
		logic [CAL_W-1:0] cal_offset_temp_coeff;
		logic [CAL_W-1:0] cal_reference_temp;
		logic [CAL_W-1:0] cal_temp_coeff;
	} cal_t;

	// Beat passed from the temperature front end to the pressure back end
	typedef struct packed {
		logic                     ok;
		logic [RAW_W-1:0]         d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
	} front_t;

endpackage

// File: hw/rtl/bsfoc_if.sv
`timescale 1ns / 1ps

interface bsfoc_in_if;
	logic                           valid;
	logic                           ready;
	logic [bsfoc_pkg::RAW_W-1:0]    raw_pressure;
	logic [bsfoc_pkg::RAW_W-1:0]    raw_temperature;

	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bsfoc_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [bsfoc_pkg::TEMP_W-1:0] temp_centi_c;
	logic [bsfoc_pkg::PRESS_W-1:0]       press_centi_mbar;
	logic                                valid_res;

	modport source (output valid, output temp_centi_c, output press_centi_mbar,
		output valid_res, input ready);
	modport sink   (input valid, input temp_centi_c, input press_centi_mbar,
		input valid_res, output ready);
endinterface

// File: hw/rtl/bsfoc_cal_regs.sv
`timescale 1ns / 1ps

module bsfoc_cal_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bsfoc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bsfoc_pkg::CAL_W-1:0]       cfg_wdata,
	output bsfoc_pkg::cal_t                   cal
);
	import bsfoc_pkg::*;

	cal_t cal_q;

	// Decode the index and write one calibration word; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PRESSURE_SENS:     cal_q.cal_pressure_sens     <= cfg_wdata;
				CFG_PRESSURE_OFFSET:   cal_q.cal_pressure_offset   <= cfg_wdata;
				CFG_SENS_TEMP_COEFF:   cal_q.cal_sens_temp_coeff   <= cfg_wdata;
				CFG_OFFSET_TEMP_COEFF: cal_q.cal_offset_temp_coeff <= cfg_wdata;
				CFG_REFERENCE_TEMP:    cal_q.cal_reference_temp    <= cfg_wdata;
				CFG_TEMP_COEFF:        cal_q.cal_temp_coeff        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cal = cal_q;

endmodule

// File: hw/rtl/bsfoc_front.sv
`timescale 1ns / 1ps

// Stages 1 to 3: dT, the three dT products, then TEMP, OFF and SENS.
module bsfoc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bsfoc_pkg::cal_t               cal,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bsfoc_pkg::RAW_W-1:0]   raw_pressure,
	input  logic [bsfoc_pkg::RAW_W-1:0]   raw_temperature,
	output logic                          out_valid,
	input  logic                          out_ready,
	output bsfoc_pkg::front_t             out_beat
);
	import bsfoc_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	logic                    ok_s1, ok_s2;
	logic [RAW_W-1:0]        d1_s1, d1_s2;
	logic signed [DT_W-1:0]  dt_s1;
	logic signed [PRD_W-1:0] prod_t_s2, prod_o_s2, prod_s_s2;
	front_t                  beat_s3;

	logic signed [DT_W-1:0]   dt_c;
	logic signed [PRD_W-1:0]  t_shift, o_shift, s_shift;
	logic signed [TSUM_W-1:0] temp_sum;
	logic signed [TSUM_W-1:0] temp_clip;
	logic signed [OFF_W-1:0]  off_c;
	logic signed [SENS_W-1:0] sens_c;

	// A stage takes a beat when it is empty or its content moves on
	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: temperature difference to the reference
	assign dt_c = $signed({1'b0, raw_temperature})
		- $signed({1'b0, cal.cal_reference_temp, {REF_SHIFT{1'b0}}});

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ok_s1 <= (raw_pressure != '0) && (raw_temperature != '0);
			d1_s1 <= raw_pressure;
			dt_s1 <= dt_c;
		end
	end

	// Stage 2: one multiplier for each coefficient
	always_ff @(posedge clk) begin
		if (en_s2) begin
			ok_s2     <= ok_s1;
			d1_s2     <= d1_s1;
			prod_t_s2 <= dt_s1 * $signed({1'b0, cal.cal_temp_coeff});
			prod_o_s2 <= dt_s1 * $signed({1'b0, cal.cal_offset_temp_coeff});
			prod_s_s2 <= dt_s1 * $signed({1'b0, cal.cal_sens_temp_coeff});
		end
	end

	// Stage 3: floor shifts, offsets and the temperature clamp
	always_comb begin
		t_shift  = prod_t_s2 >>> TEMP_SHIFT;
		o_shift  = prod_o_s2 >>> OFF_SHIFT;
		s_shift  = prod_s_s2 >>> SENS_SHIFT;
		temp_sum = t_shift[TSUM_W-1:0] + TEMP_BASE;
		if (temp_sum < TEMP_MIN) begin
			temp_clip = TEMP_MIN;
		end else if (temp_sum > TEMP_MAX) begin
			temp_clip = TEMP_MAX;
		end else begin
			temp_clip = temp_sum;
		end
		off_c  = $signed({{(OFF_W-CAL_W-OFF_SCALE){1'b0}}, cal.cal_pressure_offset,
			{OFF_SCALE{1'b0}}}) + o_shift[OFF_W-1:0];
		sens_c = $signed({{(SENS_W-CAL_W-SENS_SCALE){1'b0}}, cal.cal_pressure_sens,
			{SENS_SCALE{1'b0}}}) + s_shift[SENS_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			beat_s3.ok   <= ok_s2;
			beat_s3.d1   <= d1_s2;
			beat_s3.temp <= temp_clip[TEMP_W-1:0];
			beat_s3.off  <= off_c;
			beat_s3.sens <= sens_c;
		end
	end

	assign out_valid = v_s3;
	assign out_beat  = beat_s3;

endmodule

// File: hw/rtl/bsfoc_press.sv
`timescale 1ns / 1ps

// Stages 4 to 7: raw pressure times SENS in two halves, sum, subtract OFF, clamp.
module bsfoc_press (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  bsfoc_pkg::front_t                    in_beat,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [bsfoc_pkg::TEMP_W-1:0]  temp_centi_c,
	output logic [bsfoc_pkg::PRESS_W-1:0]        press_centi_mbar,
	output logic                                 valid_res
);
	import bsfoc_pkg::*;

	logic v_s4, v_s5, v_s6, v_s7;
	logic en_s4, en_s5, en_s6, en_s7;

	logic                     ok_s4, ok_s5, ok_s6, ok_s7;
	logic signed [TEMP_W-1:0] temp_s4, temp_s5, temp_s6, temp_s7;
	logic signed [OFF_W-1:0]  off_s4, off_s5;
	logic [PP_W-1:0]          pp_lo_s4;
	logic signed [PP_W-1:0]   pp_hi_s4;
	logic signed [PSH_W-1:0]  psh_s5;
	logic signed [DIFF_W-1:0] diff_s6;
	logic [PRESS_W-1:0]       press_s7;

	logic [LO_W-1:0]          sens_lo;
	logic signed [HI_W-1:0]   sens_hi;
	logic signed [MUL_W-1:0]  mul_full;
	logic signed [MUL_W-1:0]  mul_shift;
	logic signed [DIFF_W-1:0] diff_shift;
	logic signed [PQ_W-1:0]   p_c;
	logic [PRESS_W-1:0]       press_clip;

	assign en_s7    = !v_s7 || out_ready;
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign in_ready = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s4) v_s4 <= in_valid;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// Stage 4: split SENS into an unsigned low and a signed high slice
	assign sens_lo = in_beat.sens[LO_W-1:0];
	assign sens_hi = in_beat.sens[SENS_W-1:LO_W];

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ok_s4    <= in_beat.ok;
			temp_s4  <= in_beat.temp;
			off_s4   <= in_beat.off;
			pp_lo_s4 <= PP_W'(in_beat.d1) * PP_W'(sens_lo);
			pp_hi_s4 <= $signed({1'b0, in_beat.d1}) * sens_hi;
		end
	end

	// Stage 5: join the partial products and take the floor shift
	assign mul_full  = $signed({pp_hi_s4, {LO_W{1'b0}}})
		+ $signed({{(MUL_W-PP_W){1'b0}}, pp_lo_s4});
	assign mul_shift = mul_full >>> MUL_SHIFT;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			ok_s5   <= ok_s4;
			temp_s5 <= temp_s4;
			off_s5  <= off_s4;
			psh_s5  <= mul_shift[PSH_W-1:0];
		end
	end

	// Stage 6: subtract the offset
	always_ff @(posedge clk) begin
		if (en_s6) begin
			ok_s6   <= ok_s5;
			temp_s6 <= temp_s5;
			diff_s6 <= $signed({psh_s5[PSH_W-1], psh_s5})
				- $signed({{(DIFF_W-OFF_W){off_s5[OFF_W-1]}}, off_s5});
		end
	end

	// Stage 7: final floor shift and clamp to the pressure range
	always_comb begin
		diff_shift = diff_s6 >>> PRESS_SHIFT;
		p_c        = diff_shift[PQ_W-1:0];
		if (p_c < 0) begin
			press_clip = '0;
		end else if (p_c > PRESS_MAX) begin
			press_clip = PRESS_MAX[PRESS_W-1:0];
		end else begin
			press_clip = p_c[PRESS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			ok_s7    <= ok_s6;
			temp_s7  <= ok_s6 ? temp_s6 : '0;
			press_s7 <= ok_s6 ? press_clip : '0;
		end
	end

	assign out_valid        = v_s7;
	assign temp_centi_c     = temp_s7;
	assign press_centi_mbar = press_s7;
	assign valid_res        = ok_s7;

endmodule

// File: hw/rtl/baro_sensor_first_order_compensation.sv
`timescale 1ns / 1ps
// An accepted input beat passes the front stages 1 to 3 and the pressure stages 4 to 7 to its result beat.
// Throughput: one reading pair per cycle unless the result sink stalls; each of the
// seven stages holds one beat and takes the next one as soon as its content moves on.
// Depth is set by the dT multipliers and the raw pressure times SENS product,
// which is split into two partial products over two stages.
// Reset (arst_n low) empties the pipeline and clears all calibration words to zero.
module baro_sensor_first_order_compensation (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bsfoc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsfoc_pkg::CAL_W-1:0]     cfg_wdata,
	bsfoc_in_if.sink                        sample_in,
	bsfoc_out_if.source                     result_out
);
	import bsfoc_pkg::*;

	cal_t   cal;
	logic   mid_valid;
	logic   mid_ready;
	front_t mid_beat;

	bsfoc_cal_regs u_cal_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cal       (cal)
	);

	bsfoc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cal             (cal),
		.in_valid        (sample_in.valid),
		.in_ready        (sample_in.ready),
		.raw_pressure    (sample_in.raw_pressure),
		.raw_temperature (sample_in.raw_temperature),
		.out_valid       (mid_valid),
		.out_ready       (mid_ready),
		.out_beat        (mid_beat)
	);

	bsfoc_press u_press (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (mid_valid),
		.in_ready         (mid_ready),
		.in_beat          (mid_beat),
		.out_valid        (result_out.valid),
		.out_ready        (result_out.ready),
		.temp_centi_c     (result_out.temp_centi_c),
		.press_centi_mbar (result_out.press_centi_mbar),
		.valid_res        (result_out.valid_res)
	);

endmodule

// File: hw/rtl/bsfoc_checker.sv
`timescale 1ns / 1ps

module bsfoc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [bsfoc_pkg::RAW_W-1:0]         raw_pressure,
	input logic [bsfoc_pkg::RAW_W-1:0]         raw_temperature,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [bsfoc_pkg::TEMP_W-1:0] temp_centi_c,
	input logic [bsfoc_pkg::PRESS_W-1:0]       press_centi_mbar,
	input logic                                valid_res
);
	import bsfoc_pkg::*;

	// An invalid result carries zero readings
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> temp_centi_c == '0 && press_centi_mbar == '0)
		else $error("invalid result with nonzero fields");

	// A valid result stays within the saturation limits
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |->
			temp_centi_c >= $signed(TEMP_MIN[TEMP_W-1:0])
			&& temp_centi_c <= $signed(TEMP_MAX[TEMP_W-1:0])
			&& press_centi_mbar <= PRESS_MAX[PRESS_W-1:0])
		else $error("result outside the output range");

	// A stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(temp_centi_c)
			&& $stable(press_centi_mbar) && $stable(valid_res))
		else $error("result beat changed while stalled");

	// With the sink ready throughout, an accepted beat comes out with the right flag
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_valid && in_ready, 7)
		&& $past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3)
		&& $past(arst_n, 4) && $past(arst_n, 5) && $past(arst_n, 6) && $past(arst_n, 7)
		&& $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3)
		&& $past(out_ready, 4) && $past(out_ready, 5) && $past(out_ready, 6)
		|-> out_valid
			&& valid_res == ($past(raw_pressure, 7) != '0 && $past(raw_temperature, 7) != '0))
		else $error("result missing or wrong flag after seven cycles");

endmodule

bind baro_sensor_first_order_compensation bsfoc_checker u_bsfoc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (sample_in.valid),
	.in_ready         (sample_in.ready),
	.raw_pressure     (sample_in.raw_pressure),
	.raw_temperature  (sample_in.raw_temperature),
	.out_valid        (result_out.valid),
	.out_ready        (result_out.ready),
	.temp_centi_c     (result_out.temp_centi_c),
	.press_centi_mbar (result_out.press_centi_mbar),
	.valid_res        (result_out.valid_res)
);

// File: tb/sv/baro_sensor_first_order_compensation_test.sv
`timescale 1ns / 1ps

module baro_sensor_first_order_compensation_test;
	import bsfoc_pkg::*;

	localparam int          CLK_HALF      = 6;
	localparam int          RESET_CYCLES  = 6;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          NUM_PHASES    = 12;
	localparam int          PHASE_ITEMS   = 120;
	localparam int          END_WAIT_MAX  = 4000;
	localparam longint      RUN_LIMIT_NS  = 64'd5_000_000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam logic [RAW_W-1:0]     RAW_TOP      = {RAW_W{1'b1}};
	localparam logic [CAL_W-1:0]     CAL_TOP      = {CAL_W{1'b1}};

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic [PRESS_W-1:0]       press;
		logic                     ok;
	} reading_t;

	localparam reading_t NO_READING = '0;

	// Calibration sets used by the directed table
	typedef enum logic [2:0] {
		CAL_KEEP,
		CAL_ZERO,
		CAL_SENS_TOP,
		CAL_OFF_TOP,
		CAL_TCOEF_TOP,
		CAL_ALL_TOP,
		CAL_TYPICAL
	} cal_pick_t;

	typedef struct packed {
		cal_pick_t        pick;
		logic [RAW_W-1:0] raw_p;
		logic [RAW_W-1:0] raw_t;
		logic             typed;
		reading_t         want;
	} row_t;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_RANDOM,
		SINK_PERIODIC,
		SINK_LONG
	} sink_mode_t;

	localparam int NUM_ROWS = 21;
	row_t directed_rows [NUM_ROWS] = '{
		'{CAL_ZERO,      24'h000001, 24'h000001, 1'b1, '{15'sd2000, 18'd0, 1'b1}},
		'{CAL_KEEP,      24'hFFFFFF, 24'hFFFFFF, 1'b1, '{15'sd2000, 18'd0, 1'b1}},
		'{CAL_KEEP,      24'h000000, 24'h000005, 1'b1, NO_READING},
		'{CAL_KEEP,      24'h000005, 24'h000000, 1'b1, NO_READING},
		'{CAL_KEEP,      24'h000000, 24'h000000, 1'b1, NO_READING},
		'{CAL_SENS_TOP,  24'hFFFFFF, 24'h800000, 1'b1, '{15'sd2000, 18'd200000, 1'b1}},
		'{CAL_KEEP,      24'h000001, 24'h000001, 1'b0, NO_READING},
		'{CAL_KEEP,      24'h000000, 24'hFFFFFF, 1'b1, NO_READING},
		'{CAL_OFF_TOP,   24'hFFFFFF, 24'hFFFFFF, 1'b1, '{15'sd2000, 18'd0, 1'b1}},
		'{CAL_TCOEF_TOP, 24'h000001, 24'hFFFFFF, 1'b1, '{15'sd8500, 18'd0, 1'b1}},
		'{CAL_KEEP,      24'h000001, 24'h000001, 1'b1, '{15'sd2000, 18'd0, 1'b1}},
		'{CAL_ALL_TOP,   24'hFFFFFF, 24'hFFFFFF, 1'b0, NO_READING},
		'{CAL_KEEP,      24'hFFFFFF, 24'h000001, 1'b0, NO_READING},
		'{CAL_KEEP,      24'hAAAAAA, 24'h555555, 1'b0, NO_READING},
		'{CAL_KEEP,      24'h555555, 24'hAAAAAA, 1'b0, NO_READING},
		'{CAL_KEEP,      24'h800000, 24'hFFFF00, 1'b0, NO_READING},
		'{CAL_KEEP,      24'h000000, 24'hFFFFFF, 1'b1, NO_READING},
		'{CAL_TYPICAL,   24'd6465444, 24'd8077636, 1'b0, NO_READING},
		'{CAL_KEEP,      24'd4000000, 24'd7000000, 1'b0, NO_READING},
		'{CAL_KEEP,      24'd9000000, 24'd9000000, 1'b0, NO_READING},
		'{CAL_KEEP,      24'h000001, 24'h000001, 1'b0, NO_READING}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CAL_W-1:0] cfg_wdata;

	bsfoc_in_if  sample_bus ();
	bsfoc_out_if result_bus ();

	baro_sensor_first_order_compensation u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.sample_in  (sample_bus),
		.result_out (result_bus)
	);

	cal_t        cal_shadow;
	reading_t    pending_readings [$];
	int          mismatches;
	int unsigned burst_left;
	int unsigned gap_max;
	int unsigned burst_max;
	sink_mode_t  sink_mode;
	int unsigned sink_period;
	int unsigned sink_hold;
	int unsigned stall_tick = 0;
	int unsigned stall_left = 0;

	// Compensated reading for one raw pair under the current calibration
	function automatic reading_t compensate(input logic [RAW_W-1:0] raw_p,
			input logic [RAW_W-1:0] raw_t);
		longint   d1;
		longint   d2;
		longint   dt;
		longint   tc;
		longint   off;
		longint   sens;
		longint   pc;
		reading_t r;
		r = NO_READING;
		if (raw_p == '0 || raw_t == '0)
			return r;
		d1 = longint'(raw_p);
		d2 = longint'(raw_t);
		dt = d2 - longint'(cal_shadow.cal_reference_temp) * 256;
		tc = 2000 + ((dt * longint'(cal_shadow.cal_temp_coeff)) >>> 23);
		off = longint'(cal_shadow.cal_pressure_offset) * 131072
			+ ((longint'(cal_shadow.cal_offset_temp_coeff) * dt) >>> 6);
		sens = longint'(cal_shadow.cal_pressure_sens) * 65536
			+ ((longint'(cal_shadow.cal_sens_temp_coeff) * dt) >>> 7);
		pc = (((d1 * sens) >>> 21) - off) >>> 15;
		if (tc < -4000)
			tc = -4000;
		if (tc > 8500)
			tc = 8500;
		if (pc < 0)
			pc = 0;
		if (pc > 200000)
			pc = 200000;
		r.temp  = tc[TEMP_W-1:0];
		r.press = pc[PRESS_W-1:0];
		r.ok    = 1'b1;
		return r;
	endfunction

	function automatic cal_t cal_for(input cal_pick_t pick);
		cal_t c;
		c = '0;
		case (pick)
			CAL_SENS_TOP:  c.cal_pressure_sens = CAL_TOP;
			CAL_OFF_TOP:   c.cal_pressure_offset = CAL_TOP;
			CAL_TCOEF_TOP: c.cal_temp_coeff = CAL_TOP;
			CAL_ALL_TOP:   c = '1;
			CAL_TYPICAL: begin
				c.cal_pressure_sens     = 16'd46372;
				c.cal_pressure_offset   = 16'd43981;
				c.cal_sens_temp_coeff   = 16'd29059;
				c.cal_offset_temp_coeff = 16'd27842;
				c.cal_reference_temp    = 16'd31553;
				c.cal_temp_coeff        = 16'd28165;
			end
			default: c = '0;
		endcase
		return c;
	endfunction

	// One calibration word: zero, full scale, anything, or near a typical part
	function automatic logic [CAL_W-1:0] pick_cal_word(input logic [CAL_W-1:0] typical);
		int v;
		case ($urandom_range(0, 3))
			0: return '0;
			1: return CAL_TOP;
			2: return CAL_W'($urandom);
			default: begin
				v = int'(typical) + int'($urandom_range(0, 8191)) - 4096;
				return CAL_W'(v);
			end
		endcase
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw_p();
		case ($urandom_range(0, 31))
			0:       return '0;
			1:       return RAW_TOP;
			2:       return RAW_W'(1);
			3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14:
				return RAW_W'($urandom_range(4000000, 10000000));
			default: return RAW_W'($urandom);
		endcase
	endfunction

	// Raw temperature, often close to the reference so dT stays small
	function automatic logic [RAW_W-1:0] pick_raw_t();
		int v;
		case ($urandom_range(0, 31))
			0:       return '0;
			1:       return RAW_TOP;
			2:       return RAW_W'(1);
			3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16: begin
				v = int'(cal_shadow.cal_reference_temp) * 256
					+ int'($urandom_range(0, 1 << 20)) - (1 << 19);
				if (v < 1)
					v = 1;
				if (v > int'(RAW_TOP))
					v = int'(RAW_TOP);
				return RAW_W'(v);
			end
			default: return RAW_W'($urandom);
		endcase
	endfunction

	// Write one register and mirror it; out-of-range indexes are dropped
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			CFG_PRESSURE_SENS:     cal_shadow.cal_pressure_sens = data;
			CFG_PRESSURE_OFFSET:   cal_shadow.cal_pressure_offset = data;
			CFG_SENS_TEMP_COEFF:   cal_shadow.cal_sens_temp_coeff = data;
			CFG_OFFSET_TEMP_COEFF: cal_shadow.cal_offset_temp_coeff = data;
			CFG_REFERENCE_TEMP:    cal_shadow.cal_reference_temp = data;
			CFG_TEMP_COEFF:        cal_shadow.cal_temp_coeff = data;
			default: ;
		endcase
	endtask

	task automatic load_cal(input cal_t c);
		write_reg(CFG_SPARE_LO, CAL_W'($urandom));
		write_reg(CFG_PRESSURE_SENS, c.cal_pressure_sens);
		write_reg(CFG_PRESSURE_OFFSET, c.cal_pressure_offset);
		write_reg(CFG_SENS_TEMP_COEFF, c.cal_sens_temp_coeff);
		write_reg(CFG_OFFSET_TEMP_COEFF, c.cal_offset_temp_coeff);
		write_reg(CFG_REFERENCE_TEMP, c.cal_reference_temp);
		write_reg(CFG_TEMP_COEFF, c.cal_temp_coeff);
		write_reg(CFG_SPARE_HI, CAL_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Drop valid and hold until every pending reading has come out
	task automatic quiesce();
		sample_bus.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offer one raw pair, with a gap before it whenever a burst runs out
	task automatic send_reading(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t,
			input logic typed, input reading_t want);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, burst_max);
			if (gap != 0) begin
				sample_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sample_bus.valid           <= 1'b1;
		sample_bus.raw_pressure    <= raw_p;
		sample_bus.raw_temperature <= raw_t;
		do
			@(posedge clk);
		while (!sample_bus.ready);
		pending_readings.push_back(typed ? want : compensate(raw_p, raw_t));
	endtask

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("FAIL baro_sensor_first_order_compensation");
		$finish;
	end

	// Check each result beat and drive the receiver's stall pattern
	always @(posedge clk) begin
		reading_t want;
		if (result_bus.valid && result_bus.ready) begin
			if (pending_readings.size() == 0) begin
				$error("result beat with no reading pending: temp %0d press %0d ok %0b",
					result_bus.temp_centi_c, result_bus.press_centi_mbar,
					result_bus.valid_res);
				mismatches++;
			end else begin
				want = pending_readings.pop_front();
				if (result_bus.temp_centi_c !== want.temp) begin
					$error("temp_centi_c: expected %0d, got %0d", want.temp,
						result_bus.temp_centi_c);
					mismatches++;
				end
				if (result_bus.press_centi_mbar !== want.press) begin
					$error("press_centi_mbar: expected %0d, got %0d", want.press,
						result_bus.press_centi_mbar);
					mismatches++;
				end
				if (result_bus.valid_res !== want.ok) begin
					$error("valid_res: expected %0b, got %0b", want.ok,
						result_bus.valid_res);
					mismatches++;
				end
			end
		end
		case (sink_mode)
			SINK_OPEN:   result_bus.ready <= 1'b1;
			SINK_RANDOM: result_bus.ready <= 1'($urandom_range(0, 1));
			SINK_PERIODIC: begin
				stall_tick++;
				result_bus.ready <= (stall_tick % sink_period) >= sink_hold;
			end
			default: begin
				if (stall_left != 0) begin
					stall_left--;
					result_bus.ready <= 1'b0;
				end else if ($urandom_range(0, 15) == 0) begin
					stall_left = $urandom_range(4, 24);
					result_bus.ready <= 1'b0;
				end else begin
					result_bus.ready <= 1'b1;
				end
			end
		endcase
	end

	initial begin
		cal_t        c;
		int unsigned waited;
		arst_n                     = 1'b0;
		cfg_we                     = 1'b0;
		cfg_index                  = CFG_PRESSURE_SENS;
		cfg_wdata                  = '0;
		sample_bus.valid           = 1'b0;
		sample_bus.raw_pressure    = '0;
		sample_bus.raw_temperature = '0;
		cal_shadow                 = '0;
		mismatches                 = 0;
		burst_left                 = 0;
		gap_max                    = 2;
		burst_max                  = 4;
		sink_mode                  = SINK_RANDOM;
		sink_period                = 4;
		sink_hold                  = 1;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; a calibration change waits for the pipeline to empty
		foreach (directed_rows[i]) begin
			if (directed_rows[i].pick != CAL_KEEP) begin
				quiesce();
				load_cal(cal_for(directed_rows[i].pick));
			end
			send_reading(directed_rows[i].raw_p, directed_rows[i].raw_t,
				directed_rows[i].typed, directed_rows[i].want);
		end

		// Random phases, each with fresh calibration and handshake pressure
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			quiesce();
			c.cal_pressure_sens     = pick_cal_word(16'd46372);
			c.cal_pressure_offset   = pick_cal_word(16'd43981);
			c.cal_sens_temp_coeff   = pick_cal_word(16'd29059);
			c.cal_offset_temp_coeff = pick_cal_word(16'd27842);
			c.cal_reference_temp    = pick_cal_word(16'd31553);
			c.cal_temp_coeff        = pick_cal_word(16'd28165);
			if (ph == 0)
				c = '0;
			else if (ph == 1)
				c = '1;
			load_cal(c);
			sink_mode   = sink_mode_t'(ph % 4);
			sink_period = $urandom_range(2, 9);
			sink_hold   = $urandom_range(1, sink_period - 1);
			gap_max     = (ph % 3 == 0) ? 0 : $urandom_range(1, 6);
			burst_max   = $urandom_range(1, 16);
			burst_left  = 0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k == PHASE_ITEMS / 2 && ph % 2 == 1)
					quiesce();
				send_reading(pick_raw_p(), pick_raw_t(), 1'b0, NO_READING);
			end
		end

		// Drain, with a bound so a lost beat is reported rather than waited on
		sample_bus.valid <= 1'b0;
		waited = 0;
		while (pending_readings.size() != 0 && waited < END_WAIT_MAX) begin
			@(posedge clk);
			waited++;
		end
		if (pending_readings.size() != 0) begin
			$error("%0d readings never came out", pending_readings.size());
			mismatches++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("PASS baro_sensor_first_order_compensation");
		else
			$display("FAIL baro_sensor_first_order_compensation");
		$finish;
	end

endmodule
